>>> hw/rtl/i2cmbs_pkg.sv
// shared types and constants of the i2c master bit sequencer
// phase codes, command codes, register indexes and the sequencer state record
// no dependencies
package i2cmbs_pkg;

	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_ST_A     = 5'd1;
	localparam logic [4:0] PH_ST_B     = 5'd2;
	localparam logic [4:0] PH_SP_A     = 5'd3;
	localparam logic [4:0] PH_SP_B     = 5'd4;
	localparam logic [4:0] PH_WR_BIT   = 5'd5;
	localparam logic [4:0] PH_WR_HIGH  = 5'd6;
	localparam logic [4:0] PH_WR_LOW   = 5'd7;
	localparam logic [4:0] PH_RD_LOW   = 5'd8;
	localparam logic [4:0] PH_RD_HIGH  = 5'd9;
	localparam logic [4:0] PH_WA_REL   = 5'd10;
	localparam logic [4:0] PH_WA_HIGH  = 5'd11;
	localparam logic [4:0] PH_WA_END   = 5'd12;
	localparam logic [4:0] PH_WA_TOLOW = 5'd13;
	localparam logic [4:0] PH_AK_SET   = 5'd14;
	localparam logic [4:0] PH_AK_HIGH  = 5'd15;
	localparam logic [4:0] PH_AK_LOW   = 5'd16;

	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_START    = 3'd1;
	localparam logic [2:0] CMD_STOP     = 3'd2;
	localparam logic [2:0] CMD_WRITE    = 3'd3;
	localparam logic [2:0] CMD_READ     = 3'd4;
	localparam logic [2:0] CMD_WAIT_ACK = 3'd5;
	localparam logic [2:0] CMD_ACK      = 3'd6;
	localparam logic [2:0] CMD_NACK     = 3'd7;

	localparam logic REG_TICKS_PER_US = 1'b0;
	localparam logic REG_POLL_LIMIT   = 1'b1;

	localparam logic [7:0]  TICKS_PER_US_RST = 8'd9;
	localparam logic [15:0] POLL_LIMIT_RST   = 16'd256;

	// delays in microseconds
	localparam logic [2:0] US_LONG  = 3'd4;
	localparam logic [2:0] US_SHORT = 3'd1;
	localparam logic [2:0] US_NONE  = 3'd0;

	localparam logic [3:0] LAST_BIT = 4'd7;

	typedef struct packed {
		logic [4:0]  phase;
		logic [3:0]  bit_cnt;
		logic [2:0]  us_rem;
		logic [7:0]  prescale;
		logic [7:0]  shift;
		logic [15:0] poll_cnt;
		logic        scl;
		logic        sda;
		logic        sda_oe;
		logic [7:0]  read_data;
		logic        ack_status;
	} seq_state_t;

	typedef struct packed {
		logic [7:0]  ticks_per_us;
		logic [15:0] poll_limit;
	} seq_cfg_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_status;
	} seq_result_t;

	localparam seq_state_t STATE_RST = '{
		phase: PH_IDLE, bit_cnt: 4'd0, us_rem: 3'd0, prescale: 8'd0, shift: 8'd0,
		poll_cnt: 16'd0, scl: 1'b1, sda: 1'b1, sda_oe: 1'b0, read_data: 8'd0,
		ack_status: 1'b0
	};

endpackage

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
// top level of the i2c master bit sequencer: stream ports, input and result registers
// uses i2cmbs_pkg and i2cmbs_seq
//
// Usage:
//   Every slave beat is one bus tick carrying a command, a write byte and the
//   sampled SDA level. Every tick yields exactly one master beat with the pin
//   drive, busy and done flags, the last read byte and the acknowledge status.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   index 0 is ticks per microsecond, index 1 the acknowledge poll limit.
//   A beat accepted from the slave side is registered in the input register,
//   stepped through the sequencer into the result register once that register
//   is free, and shows on the master side from then on.
//   Throughput: one beat per cycle while results are taken; the tick update
//   is a single pass of next-state logic between the input and result registers.
//   If the receiver stalls, the result register holds its beat, the input
//   register fills and s_tready drops until the result is taken.
//   Reset: SCL high, SDA released, sequencer idle, registers at their
//   defaults (9 ticks per microsecond, poll limit 256), both channels empty.
module i2c_master_bit_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // command[2:0], write_data[10:3], sda_in[11], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // scl_level[0], sda_level[1], sda_drive_enable[2],
	                              // busy_res[3], done_res[4], read_data[12:5],
	                              // ack_status[13], zero
);
	import i2cmbs_pkg::*;

	logic        valid_s1;
	logic [2:0]  command_s1;
	logic [7:0]  write_data_s1;
	logic        sda_in_s1;
	logic        step_en;
	seq_result_t res;
	logic [13:0] out_q;

	assign step_en  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1    <= s_tdata[2:0];
			write_data_s1 <= s_tdata[10:3];
			sda_in_s1     <= s_tdata[11];
		end
	end

	i2cmbs_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step_en    (step_en),
		.command    (command_s1),
		.write_data (write_data_s1),
		.sda_in     (sda_in_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q <= {res.ack_status, res.read_data, res.done_res, res.busy_res,
				res.sda_drive_enable, res.sda_level, res.scl_level};
		end
	end

	assign m_tdata = {2'b00, out_q};

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted with both stages full");
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:14] == 2'b00)
		else $error("result padding not zero");
`endif

endmodule

>>> hw/rtl/i2cmbs_step.sv
// next-state logic of the i2c master bit sequencer for one tick
// pure combinational; uses i2cmbs_pkg
module i2cmbs_step (
	input  i2cmbs_pkg::seq_state_t cur,
	input  i2cmbs_pkg::seq_cfg_t   cfg,
	input  logic [2:0]             command,
	input  logic [7:0]             write_data,
	input  logic                   sda_in,
	output i2cmbs_pkg::seq_state_t nxt,
	output logic                   done
);
	import i2cmbs_pkg::*;

	logic [15:0] lim_eff;
	logic        poll_out;
	logic        tick_wrap;

	assign lim_eff   = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;
	assign poll_out  = ({1'b0, cur.poll_cnt} + 17'd1) >= {1'b0, lim_eff};
	assign tick_wrap = ({1'b0, cur.prescale} + 9'd1) >= {1'b0, cfg.ticks_per_us};

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (cur.phase == PH_IDLE) begin
			if (command != CMD_NONE) begin
				nxt.bit_cnt  = 4'd0;
				nxt.prescale = 8'd0;
			end
			unique case (command)
				CMD_START: begin
					nxt.scl = 1'b1; nxt.sda = 1'b1; nxt.sda_oe = 1'b1;
					nxt.phase = PH_ST_A; nxt.us_rem = US_LONG;
				end
				CMD_STOP: begin
					nxt.scl = 1'b1; nxt.sda = 1'b0; nxt.sda_oe = 1'b1;
					nxt.phase = PH_SP_A; nxt.us_rem = US_LONG;
				end
				CMD_WRITE: begin
					nxt.shift = write_data;
					nxt.sda = write_data[7]; nxt.sda_oe = 1'b1;
					nxt.phase = PH_WR_BIT; nxt.us_rem = US_SHORT;
				end
				CMD_READ: begin
					nxt.shift = 8'd0;
					nxt.sda = 1'b1; nxt.sda_oe = 1'b0;
					nxt.phase = PH_RD_LOW; nxt.us_rem = US_SHORT;
				end
				CMD_WAIT_ACK: begin
					nxt.poll_cnt = 16'd0;
					nxt.sda = 1'b1; nxt.sda_oe = 1'b0;
					nxt.phase = PH_WA_REL; nxt.us_rem = US_SHORT;
				end
				CMD_ACK: begin
					nxt.sda = 1'b0; nxt.sda_oe = 1'b1;
					nxt.phase = PH_AK_SET; nxt.us_rem = US_SHORT;
				end
				CMD_NACK: begin
					nxt.sda = 1'b1; nxt.sda_oe = 1'b1;
					nxt.phase = PH_AK_SET; nxt.us_rem = US_SHORT;
				end
				default: ;
			endcase
		end else if (cur.us_rem != 3'd0) begin
			if (tick_wrap) begin
				nxt.prescale = 8'd0;
				nxt.us_rem   = cur.us_rem - 3'd1;
			end else begin
				nxt.prescale = cur.prescale + 8'd1;
			end
		end else begin
			nxt.prescale = 8'd0;
			unique case (cur.phase)
				PH_ST_A: begin
					nxt.sda = 1'b0; nxt.sda_oe = 1'b1;
					nxt.phase = PH_ST_B; nxt.us_rem = US_LONG;
				end
				PH_ST_B: begin
					nxt.scl = 1'b0; done = 1'b1;
				end
				PH_SP_A: begin
					nxt.sda = 1'b1; nxt.sda_oe = 1'b1;
					nxt.phase = PH_SP_B; nxt.us_rem = US_LONG;
				end
				PH_SP_B: begin
					nxt.sda = 1'b1; nxt.sda_oe = 1'b0; done = 1'b1;
				end
				PH_WR_BIT: begin
					nxt.scl = 1'b1; nxt.phase = PH_WR_HIGH; nxt.us_rem = US_LONG;
				end
				PH_WR_HIGH: begin
					nxt.scl = 1'b0;
					if (cur.bit_cnt >= LAST_BIT) begin
						done = 1'b1;
					end else begin
						nxt.phase = PH_WR_LOW; nxt.us_rem = US_NONE;
					end
				end
				PH_WR_LOW: begin
					nxt.bit_cnt = cur.bit_cnt + 4'd1;
					nxt.shift   = {cur.shift[6:0], 1'b0};
					nxt.sda = cur.shift[6]; nxt.sda_oe = 1'b1;
					nxt.phase = PH_WR_BIT; nxt.us_rem = US_SHORT;
				end
				PH_RD_LOW: begin
					nxt.scl = 1'b1; nxt.phase = PH_RD_HIGH; nxt.us_rem = US_NONE;
				end
				PH_RD_HIGH: begin
					nxt.shift = {cur.shift[6:0], sda_in};
					nxt.scl   = 1'b0;
					if (cur.bit_cnt >= LAST_BIT) begin
						nxt.read_data = {cur.shift[6:0], sda_in};
						done = 1'b1;
					end else begin
						nxt.bit_cnt = cur.bit_cnt + 4'd1;
						nxt.phase = PH_RD_LOW; nxt.us_rem = US_SHORT;
					end
				end
				PH_WA_REL: begin
					nxt.scl = 1'b1; nxt.phase = PH_WA_HIGH; nxt.us_rem = US_SHORT;
				end
				PH_WA_HIGH: begin
					if (!sda_in) begin
						nxt.scl = 1'b0; nxt.ack_status = 1'b0;
						nxt.phase = PH_WA_END; nxt.us_rem = US_SHORT;
					end else if (poll_out) begin
						nxt.scl = 1'b0; nxt.ack_status = 1'b1;
						nxt.phase = PH_WA_TOLOW; nxt.us_rem = US_NONE;
					end else begin
						nxt.poll_cnt = cur.poll_cnt + 16'd1;
						nxt.us_rem = US_NONE;
					end
				end
				PH_WA_END: done = 1'b1;
				PH_WA_TOLOW: begin
					// timeout: release the bus with a stop
					nxt.scl = 1'b1; nxt.sda = 1'b0; nxt.sda_oe = 1'b1;
					nxt.phase = PH_SP_A; nxt.us_rem = US_LONG;
				end
				PH_AK_SET: begin
					nxt.scl = 1'b1; nxt.phase = PH_AK_HIGH; nxt.us_rem = US_LONG;
				end
				PH_AK_HIGH: begin
					nxt.scl = 1'b0; nxt.phase = PH_AK_LOW; nxt.us_rem = US_LONG;
				end
				PH_AK_LOW: begin
					nxt.sda = 1'b1; nxt.sda_oe = 1'b0; done = 1'b1;
				end
				default: done = 1'b1;
			endcase
			if (done) begin
				nxt.phase  = PH_IDLE;
				nxt.us_rem = 3'd0;
			end
		end
	end

endmodule

>>> hw/rtl/i2cmbs_seq.sv
// sequencer state and configuration registers of the i2c master bit sequencer
// uses i2cmbs_pkg and i2cmbs_step
module i2cmbs_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    step_en,
	input  logic [2:0]              command,
	input  logic [7:0]              write_data,
	input  logic                    sda_in,
	output i2cmbs_pkg::seq_result_t res
);
	import i2cmbs_pkg::*;

	seq_state_t state_q;
	seq_state_t state_nxt;
	seq_cfg_t   cfg_q;
	logic       done;

	i2cmbs_step u_step (
		.cur        (state_q),
		.cfg        (cfg_q),
		.command    (command),
		.write_data (write_data),
		.sda_in     (sda_in),
		.nxt        (state_nxt),
		.done       (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_us <= TICKS_PER_US_RST;
			cfg_q.poll_limit   <= POLL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_data[7:0];
				REG_POLL_LIMIT:   cfg_q.poll_limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	// result reflects the state after this tick
	assign res.scl_level        = state_nxt.scl;
	assign res.sda_level        = state_nxt.sda;
	assign res.sda_drive_enable = state_nxt.sda_oe;
	assign res.busy_res         = state_nxt.phase != PH_IDLE;
	assign res.done_res         = done;
	assign res.read_data        = state_nxt.read_data;
	assign res.ack_status       = state_nxt.ack_status;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && done |=> state_q.phase == PH_IDLE)
		else $error("done without return to idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(state_q))
		else $error("state moved without a tick");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> state_q.us_rem == 3'd0 && state_q.prescale == 8'd0)
		else $error("idle with a delay pending");
`endif

endmodule

>>> test/sequencer_checker.sv
// checker for the i2c master bit sequencer: watches the register port and both stream channels
// keeps its own copy of the sequencer, predicts one result beat per tick and compares fields
// depends on i2cmbs_pkg
`timescale 1ns / 100ps
module sequencer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // command[2:0], write_data[10:3], sda_in[11], zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // scl_level[0], sda_level[1], sda_drive_enable[2],
	                               // busy_res[3], done_res[4], read_data[12:5],
	                               // ack_status[13], zero
	output int          errors,
	output int          outstanding,
	output int          checked,
	output int          ack_timeouts,
	output logic        seq_idle
);
	import i2cmbs_pkg::*;

	seq_state_t  bus;
	seq_cfg_t    regs;
	seq_result_t pending_ticks[$];

	task automatic report_fault(input string msg);
		// keep the log readable if the block is badly broken
		if (errors < 50)
			$display("[%0t] sequencer check: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int got_v, input int want_v);
		if (got_v != want_v)
			report_fault($sformatf("beat %0d: %s is %0h, expected %0h", checked, name, got_v,
				want_v));
	endtask

	function automatic void enter_phase(input logic [4:0] ph, input logic [2:0] us);
		bus.phase = ph;
		bus.us_rem = us;
		bus.prescale = '0;
	endfunction

	function automatic void start_stop();
		bus.scl = 1'b1;
		bus.sda = 1'b0;
		bus.sda_oe = 1'b1;
		enter_phase(PH_SP_A, US_LONG);
	endfunction

	// one step of the pin sequence once the current delay has run out; 1 when the command ends
	function automatic logic step_phase(input logic sda_in);
		logic [16:0] limit;
		limit = (regs.poll_limit == 16'd0) ? 17'd1 : {1'b0, regs.poll_limit};
		step_phase = 1'b0;
		case (bus.phase)
			PH_ST_A: begin
				bus.sda = 1'b0;
				bus.sda_oe = 1'b1;
				enter_phase(PH_ST_B, US_LONG);
			end
			PH_ST_B: begin
				bus.scl = 1'b0;
				step_phase = 1'b1;
			end
			PH_SP_A: begin
				bus.sda = 1'b1;
				bus.sda_oe = 1'b1;
				enter_phase(PH_SP_B, US_LONG);
			end
			PH_SP_B: begin
				bus.sda = 1'b1;
				bus.sda_oe = 1'b0;
				step_phase = 1'b1;
			end
			PH_WR_BIT: begin
				bus.scl = 1'b1;
				enter_phase(PH_WR_HIGH, US_LONG);
			end
			PH_WR_HIGH: begin
				bus.scl = 1'b0;
				if (bus.bit_cnt >= LAST_BIT)
					step_phase = 1'b1;
				else
					enter_phase(PH_WR_LOW, US_NONE);
			end
			PH_WR_LOW: begin
				bus.bit_cnt = bus.bit_cnt + 4'd1;
				bus.shift = bus.shift << 1;
				bus.sda = bus.shift[7];
				bus.sda_oe = 1'b1;
				enter_phase(PH_WR_BIT, US_SHORT);
			end
			PH_RD_LOW: begin
				bus.scl = 1'b1;
				enter_phase(PH_RD_HIGH, US_NONE);
			end
			PH_RD_HIGH: begin
				bus.shift = {bus.shift[6:0], sda_in};
				bus.scl = 1'b0;
				if (bus.bit_cnt >= LAST_BIT) begin
					bus.read_data = bus.shift;
					step_phase = 1'b1;
				end else begin
					bus.bit_cnt = bus.bit_cnt + 4'd1;
					enter_phase(PH_RD_LOW, US_SHORT);
				end
			end
			PH_WA_REL: begin
				bus.scl = 1'b1;
				enter_phase(PH_WA_HIGH, US_SHORT);
			end
			PH_WA_HIGH: begin
				if (!sda_in) begin
					bus.scl = 1'b0;
					bus.ack_status = 1'b0;
					enter_phase(PH_WA_END, US_SHORT);
				end else if ({1'b0, bus.poll_cnt} + 17'd1 >= limit) begin
					// no acknowledge: one low tick on scl, then a stop
					bus.scl = 1'b0;
					bus.ack_status = 1'b1;
					ack_timeouts++;
					enter_phase(PH_WA_TOLOW, US_NONE);
				end else begin
					bus.poll_cnt = bus.poll_cnt + 16'd1;
					enter_phase(PH_WA_HIGH, US_NONE);
				end
			end
			PH_WA_END: step_phase = 1'b1;
			PH_WA_TOLOW: start_stop();
			PH_AK_SET: begin
				bus.scl = 1'b1;
				enter_phase(PH_AK_HIGH, US_LONG);
			end
			PH_AK_HIGH: begin
				bus.scl = 1'b0;
				enter_phase(PH_AK_LOW, US_LONG);
			end
			PH_AK_LOW: begin
				bus.sda = 1'b1;
				bus.sda_oe = 1'b0;
				step_phase = 1'b1;
			end
			default: step_phase = 1'b1;
		endcase
	endfunction

	function automatic seq_result_t predict_tick(input logic [2:0] cmd, input logic [7:0] wd,
			input logic sda_in);
		seq_result_t r;
		logic        done;
		done = 1'b0;
		if (bus.phase == PH_IDLE) begin
			if (cmd != CMD_NONE)
				bus.bit_cnt = '0;
			case (cmd)
				CMD_START: begin
					bus.scl = 1'b1;
					bus.sda = 1'b1;
					bus.sda_oe = 1'b1;
					enter_phase(PH_ST_A, US_LONG);
				end
				CMD_STOP: start_stop();
				CMD_WRITE: begin
					bus.shift = wd;
					bus.sda = wd[7];
					bus.sda_oe = 1'b1;
					enter_phase(PH_WR_BIT, US_SHORT);
				end
				CMD_READ: begin
					bus.shift = '0;
					bus.sda = 1'b1;
					bus.sda_oe = 1'b0;
					enter_phase(PH_RD_LOW, US_SHORT);
				end
				CMD_WAIT_ACK: begin
					bus.poll_cnt = '0;
					bus.sda = 1'b1;
					bus.sda_oe = 1'b0;
					enter_phase(PH_WA_REL, US_SHORT);
				end
				CMD_ACK: begin
					bus.sda = 1'b0;
					bus.sda_oe = 1'b1;
					enter_phase(PH_AK_SET, US_SHORT);
				end
				CMD_NACK: begin
					bus.sda = 1'b1;
					bus.sda_oe = 1'b1;
					enter_phase(PH_AK_SET, US_SHORT);
				end
				default: ;
			endcase
		end else if (bus.us_rem != '0) begin
			// a rate of zero behaves as one tick per microsecond
			if ({1'b0, bus.prescale} + 9'd1 >= {1'b0, regs.ticks_per_us}) begin
				bus.prescale = '0;
				bus.us_rem = bus.us_rem - 3'd1;
			end else begin
				bus.prescale = bus.prescale + 8'd1;
			end
		end else if (step_phase(sda_in)) begin
			enter_phase(PH_IDLE, US_NONE);
			done = 1'b1;
		end
		r.scl_level = bus.scl;
		r.sda_level = bus.sda;
		r.sda_drive_enable = bus.sda_oe;
		r.busy_res = (bus.phase != PH_IDLE);
		r.done_res = done;
		r.read_data = bus.read_data;
		r.ack_status = bus.ack_status;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		seq_result_t got;
		seq_result_t want;
		if (!arst_n) begin
			bus = STATE_RST;
			regs.ticks_per_us = TICKS_PER_US_RST;
			regs.poll_limit = POLL_LIMIT_RST;
			pending_ticks.delete();
			errors = 0;
			checked = 0;
			ack_timeouts = 0;
			outstanding <= 0;
			seq_idle <= 1'b1;
		end else begin
			// a result never leaves on the edge its tick is taken, so compare before predicting
			if (m_tvalid && m_tready) begin
				got.scl_level = m_tdata[0];
				got.sda_level = m_tdata[1];
				got.sda_drive_enable = m_tdata[2];
				got.busy_res = m_tdata[3];
				got.done_res = m_tdata[4];
				got.read_data = m_tdata[12:5];
				got.ack_status = m_tdata[13];
				if (pending_ticks.size() == 0) begin
					report_fault($sformatf("beat %0d arrived with no tick waiting", checked));
				end else begin
					want = pending_ticks.pop_front();
					check_field("scl_level", got.scl_level, want.scl_level);
					check_field("sda_level", got.sda_level, want.sda_level);
					check_field("sda_drive_enable", got.sda_drive_enable, want.sda_drive_enable);
					check_field("busy_res", got.busy_res, want.busy_res);
					check_field("done_res", got.done_res, want.done_res);
					check_field("read_data", got.read_data, want.read_data);
					check_field("ack_status", got.ack_status, want.ack_status);
					check_field("padding", m_tdata[15:14], 0);
				end
				checked++;
			end
			if (cfg_we) begin
				if (cfg_index == REG_TICKS_PER_US)
					regs.ticks_per_us = cfg_data[7:0];
				else
					regs.poll_limit = cfg_data;
			end
			if (s_tvalid && s_tready)
				pending_ticks.push_back(predict_tick(s_tdata[2:0], s_tdata[10:3], s_tdata[11]));
			outstanding <= pending_ticks.size();
			seq_idle <= (bus.phase == PH_IDLE);
		end
	end

endmodule

>>> test/testbench.sv
// top of the i2c master bit sequencer testbench: clock, reset, tick stimulus and verdict
// drives i2c_master_bit_sequencer_unit and checks it with sequencer_checker; uses i2cmbs_pkg
`timescale 1ns / 100ps
module testbench;
	import i2cmbs_pkg::*;

	localparam int MAX_CYCLES    = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_CYCLES  = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_TICKS_PER_US;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // command[2:0], write_data[10:3], sda_in[11], zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // scl_level[0], sda_level[1], sda_drive_enable[2],
	                             // busy_res[3], done_res[4], read_data[12:5],
	                             // ack_status[13], zero

	int   errors;
	int   outstanding;
	int   checked;
	int   ack_timeouts;
	logic seq_idle;

	bit jitter_on = 1'b1;
	int stall_orders = 0;
	int stall_served = 0;
	int stall_left = 0;
	int ticks_sent = 0;
	int commands_sent = 0;
	int cycles = 0;

	i2c_master_bit_sequencer_unit DUT (.*);
	sequencer_checker bus_check (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random back-pressure, plus long hold-offs when the stimulus asks for one
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_served != stall_orders) begin
			stall_served <= stall_orders;
			stall_left <= STALL_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= jitter_on ? ($urandom_range(99) >= 17) : 1'b1;
		end
	end

	task automatic put_beat(input logic [2:0] cmd, input logic [7:0] wd, input logic sda);
		if (jitter_on && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, sda, wd, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ticks_sent++;
		if (cmd != CMD_NONE)
			commands_sent++;
	endtask

	// idle ticks until the sequencer is free again; noisy runs slip in commands it must ignore
	task automatic idle_out(input int sda_high_pct, input bit noisy);
		logic [2:0] filler;
		do begin
			filler = (noisy && $urandom_range(99) < 8) ? 3'($urandom_range(1, 7)) : CMD_NONE;
			put_beat(filler, 8'($urandom), 1'($urandom_range(99) < sda_high_pct));
		end while (!seq_idle);
	endtask

	task automatic run_command(input logic [2:0] cmd, input logic [7:0] wd,
			input int sda_high_pct, input bit noisy);
		put_beat(cmd, wd, 1'($urandom_range(1)));
		idle_out(sda_high_pct, noisy);
	endtask

	// random ack waits: slave answers at once, often, rarely, or very rarely
	function automatic int ack_high_pct();
		case ($urandom_range(3))
			0: return 0;
			1: return 60;
			2: return 90;
			default: return 97;
		endcase
	endfunction

	// start, address, then one or two write or read parts, usually closed by a stop
	task automatic run_transfer();
		int parts;
		run_command(CMD_START, 8'($urandom), 50, 1'b1);
		run_command(CMD_WRITE, 8'($urandom), 50, 1'b1);
		run_command(CMD_WAIT_ACK, 8'($urandom), ack_high_pct(), 1'b1);
		parts = $urandom_range(1, 2);
		repeat (parts) begin
			if ($urandom_range(1)) begin
				run_command(CMD_WRITE, 8'($urandom), 50, 1'b1);
				run_command(CMD_WAIT_ACK, 8'($urandom), ack_high_pct(), 1'b1);
			end else begin
				run_command(CMD_READ, 8'($urandom), 50, 1'b1);
				run_command($urandom_range(1) ? CMD_ACK : CMD_NACK, 8'($urandom), 50, 1'b1);
			end
		end
		if ($urandom_range(9) != 0)
			run_command(CMD_STOP, 8'($urandom), 50, 1'b1);
	endtask

	// stop offering until every tick has come back, then let the pipeline settle
	task automatic go_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] tpu, input logic [15:0] limit);
		cfg_we <= 1'b1;
		cfg_index <= REG_TICKS_PER_US;
		cfg_data <= {8'($urandom), tpu};
		@(posedge clk);
		cfg_index <= REG_POLL_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] tpu, input logic [15:0] limit, input bit jitter,
			input int budget, input bit hold_off);
		int stop_at;
		go_quiet();
		configure(tpu, limit);
		jitter_on <= jitter;
		if (hold_off)
			stall_orders <= stall_orders + 1;
		stop_at = ticks_sent + budget;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(4) == 0)
				run_command(3'($urandom_range(1, 7)), 8'($urandom), ack_high_pct(), 1'b1);
			else
				run_transfer();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight out of reset
		run_command(CMD_START, 8'h00, 50, 1'b0);
		run_command(CMD_WAIT_ACK, 8'h00, 0, 1'b0);
		run_command(CMD_STOP, 8'h00, 50, 1'b0);

		// directed: zero rate and zero poll limit both act as one
		go_quiet();
		configure(8'd0, 16'd0);
		put_beat(CMD_NONE, 8'hFF, 1'b1);
		put_beat(CMD_NONE, 8'h00, 1'b0);
		run_command(CMD_START, 8'h00, 50, 1'b0);
		run_command(CMD_WRITE, 8'hFF, 50, 1'b0);
		run_command(CMD_WAIT_ACK, 8'h00, 100, 1'b0);   // times out on the first high poll
		run_command(CMD_START, 8'h00, 50, 1'b0);
		run_command(CMD_WRITE, 8'h00, 50, 1'b0);
		run_command(CMD_WAIT_ACK, 8'h00, 0, 1'b0);
		run_command(CMD_WRITE, 8'hA5, 50, 1'b0);
		run_command(CMD_WAIT_ACK, 8'h00, 0, 1'b0);
		run_command(CMD_READ, 8'h00, 100, 1'b0);
		run_command(CMD_ACK, 8'h00, 50, 1'b0);
		run_command(CMD_READ, 8'hFF, 0, 1'b0);
		run_command(CMD_NACK, 8'h00, 50, 1'b0);
		run_command(CMD_STOP, 8'h00, 50, 1'b0);
		run_command(CMD_STOP, 8'h00, 50, 1'b0);
		run_command(CMD_ACK, 8'h00, 50, 1'b0);
		run_command(CMD_NACK, 8'h00, 50, 1'b0);
		// a read starts; the commands landing on it while the sequencer is busy are dropped
		put_beat(CMD_READ, 8'h00, 1'b0);
		put_beat(CMD_WRITE, 8'h5A, 1'b1);
		put_beat(CMD_NACK, 8'hC3, 1'b0);
		idle_out(50, 1'b0);

		// random transfers over a spread of rates and limits
		run_phase(8'd1, 16'd3, 1'b1, 60, 1'b0);
		run_phase(8'd2, 16'd1, 1'b0, 60, 1'b0);
		run_phase(8'd1, 16'hFFFF, 1'b1, 60, 1'b1);

		// slowest rate: only a slice of one start, left running into the next phase
		go_quiet();
		configure(8'd255, 16'd7);
		jitter_on <= 1'b1;
		put_beat(CMD_START, 8'($urandom), 1'($urandom_range(1)));
		repeat (80) put_beat(CMD_NONE, 8'($urandom), 1'($urandom_range(1)));

		run_phase(8'd3, 16'd5, 1'b1, 60, 1'b0);
		run_phase(8'd1, 16'd2, 1'b1, 60, 1'b1);
		go_quiet();

		$display("covered %0d bus ticks carrying %0d commands, %0d result beats compared",
			ticks_sent, commands_sent, checked);
		$display("rates 0 to 255 ticks per microsecond, poll limits 0 to 65535, %0d ack timeouts",
			ack_timeouts);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/i2cmbs_pkg.sv
hw/rtl/i2cmbs_step.sv
hw/rtl/i2cmbs_seq.sv
hw/rtl/i2c_master_bit_sequencer_unit.sv
test/sequencer_checker.sv
test/testbench.sv
